// ----- design/scra_pkg.sv -----
// Package for the size-class refcount allocator.
// Shared constants, header layout and a helper function; no dependencies.
`default_nettype none
package scra_pkg;
  localparam int unsigned PoolAddrBits = 24;
  localparam int unsigned SizeClasses = 18;
  localparam int unsigned SmallBits = 6;
  localparam int unsigned SlotBits = PoolAddrBits - 6;
  localparam int unsigned ClsBits = 5;
  localparam int unsigned CntBits = 32;
  localparam int unsigned HdrBits = CntBits + ClsBits + SlotBits;
  localparam int unsigned TotBits = 25;
  localparam int unsigned ListBits = $clog2(SizeClasses);

  typedef enum logic [1:0] {
    ACT_CHECKOUT = 2'd0,
    ACT_RESERVE  = 2'd1,
    ACT_REMIT    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [SlotBits-1:0] next;
    logic [ClsBits-1:0]  cls;
    logic [CntBits-1:0]  count;
  } hdr_t;

  // ceil(log2(max(n,64))) - 6; oversize requests map to classes 18 and 19
  function automatic logic [ClsBits-1:0] size_class(input logic [24:0] n);
    logic [ClsBits-1:0] c;
    c = '0;
    for (int b = 7; b <= 25; b++) begin
      if (n > 25'((33'd1 << (b - 1)))) c = ClsBits'(b - 6);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- design/scra_if.sv -----
// Valid/ready channel interfaces for the allocator.
// Depends on scra_pkg.
`default_nettype none
interface scra_req_if import scra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [24:0] request_bytes;
  logic [23:0] block_address;
  modport source (output valid, action, request_bytes, block_address, input ready);
  modport sink (input valid, action, request_bytes, block_address, output ready);
endinterface

interface scra_rsp_if import scra_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [23:0] result_address;
  logic [23:0] capacity;
  logic [31:0] ref_count;
  logic [1:0]  status;
  logic [24:0] reserved_bytes;
  logic [24:0] free_bytes;
  modport source (output valid, result_address, capacity, ref_count, status,
                  reserved_bytes, free_bytes, input ready);
  modport sink (input valid, result_address, capacity, ref_count, status,
                reserved_bytes, free_bytes, output ready);
endinterface
`default_nettype wire

// ----- design/size_class_refcount_allocator_unit.sv -----
// Top level of the size-class refcount allocator.
// Depends on scra_pkg, scra_if and scra_hdr_ram.
//
// Usage:
//   req (sink): action, request_bytes, block_address. 0 check out,
//   1 reserve, 2 remit, 3 no-op. rsp (source): one transfer per request.
//   Each request has an accept/read-header-RAM step, then a modify and
//   write-back step that loads the output register. A new request is
//   taken the cycle after the result is loaded, even while that result
//   waits, but never before. rsp.valid rises when the modify step loads
//   the output register. Only one item is in the read and modify steps
//   at a time, so no header forwarding is needed. Free-list heads (18
//   classes) sit in flops with valid bits; the header RAM has no reset.
//   The user must see that blocks are only read after being carved; the
//   block itself does not enforce it.
//   Reset: bump pointer 64, lists empty, totals zero, no output pending.
//   Receiver stall: the output register holds; one further request may be
//   accepted but waits in the read stage until the register frees.
`default_nettype none
module size_class_refcount_allocator_unit import scra_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  scra_req_if.sink   req,
  scra_rsp_if.source rsp
);
  typedef enum logic {S_IDLE, S_EXEC} state_e;
  state_e state_q;

  logic [1:0]           act_q;
  logic [ClsBits-1:0]   cls_q;
  logic [SlotBits-1:0]  slot_q;
  logic [24:0]          bump_q;
  logic [TotBits-1:0]   res_tot_q, free_tot_q;
  logic [31:0]          ckout_q;
  logic [SizeClasses-1:0] lv_q;
  logic [SlotBits-1:0]  lh_q [SizeClasses];

  logic out_valid_q;
  logic [23:0] o_addr_q, o_cap_q;
  logic [31:0] o_cnt_q;
  logic [1:0]  o_st_q;

  hdr_t rd_hdr, wr_hdr;
  logic wr_en;
  logic [SlotBits-1:0] wr_addr, rd_addr;

  logic accept, exec_go;
  assign req.ready = (state_q == S_IDLE);
  assign accept = req.valid && req.ready;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

  // read address chosen at accept: list head for checkout, header slot otherwise
  logic [ClsBits-1:0] in_cls;
  logic [ListBits-1:0] in_li;
  assign in_cls = size_class(req.request_bytes);
  assign in_li = ListBits'(in_cls);
  always_comb begin
    if (req.action == ACT_CHECKOUT) begin
      rd_addr = (in_cls < ClsBits'(SizeClasses)) ? lh_q[in_li] : '0;
    end else begin
      rd_addr = req.block_address[23:6] - SlotBits'(1);
    end
  end

  scra_hdr_ram u_ram (
    .clk_i, .rd_en_i(accept), .rd_addr_i(rd_addr), .rd_data_o(rd_hdr),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_hdr)
  );

  // execute stage
  logic [ListBits-1:0] li, hli;
  logic [24:0] size, hsize;
  logic [26:0] bump_end;
  logic [31:0] cdec;
  logic [23:0] n_addr, n_cap;
  logic [31:0] n_cnt;
  logic [1:0]  n_st;
  logic        pop, carve, push;
  assign li = ListBits'(cls_q);
  assign size = 25'd1 << (cls_q + ClsBits'(SmallBits));
  assign hli = ListBits'(rd_hdr.cls);
  assign hsize = 25'd1 << (rd_hdr.cls + ClsBits'(SmallBits));
  assign bump_end = {2'b0, bump_q} + 27'd64 + {2'b0, size};
  assign cdec = rd_hdr.count - 32'd1;

  always_comb begin
    n_addr = '0; n_cap = '0; n_cnt = '0; n_st = ST_OK;
    pop = 1'b0; carve = 1'b0; push = 1'b0;
    wr_en = 1'b0; wr_addr = slot_q; wr_hdr = rd_hdr;
    case (act_q)
      ACT_CHECKOUT: begin
        if (cls_q >= ClsBits'(SizeClasses)) begin
          n_st = ST_TOO_LARGE;
        end else if (lv_q[li]) begin
          pop = 1'b1;
          wr_en = exec_go;
          wr_addr = lh_q[li];
          wr_hdr = '{next: '0, cls: cls_q, count: 32'd1};
          n_addr = {lh_q[li], 6'd0} + 24'd64;
          n_cap = size[23:0];
        end else if (bump_end > 27'(1 << PoolAddrBits)) begin
          n_st = ST_NO_SPACE;
        end else begin
          carve = 1'b1;
          wr_en = exec_go;
          wr_addr = bump_q[23:6];
          wr_hdr = '{next: '0, cls: cls_q, count: 32'd1};
          n_addr = bump_q[23:0] + 24'd64;
          n_cap = size[23:0];
        end
      end
      ACT_RESERVE: begin
        n_cnt = rd_hdr.count;
        wr_en = exec_go;
        wr_hdr.count = rd_hdr.count + 32'd1;
      end
      ACT_REMIT: begin
        if (rd_hdr.count == '0) begin
          n_st = ST_UNDERFLOW;
        end else begin
          n_cnt = cdec;
          wr_en = exec_go;
          wr_hdr.count = cdec;
          if (cdec == '0 && rd_hdr.cls < ClsBits'(SizeClasses)) begin
            push = 1'b1;
            wr_hdr.next = lv_q[hli] ? lh_q[hli] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bump_q <= 25'd64;
      res_tot_q <= '0;
      free_tot_q <= '0;
      ckout_q <= '0;
      lv_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
      if (accept) begin
        state_q <= S_EXEC;
        act_q <= req.action;
        cls_q <= in_cls;
        slot_q <= rd_addr;
      end
      if (exec_go) begin
        state_q <= S_IDLE;
        out_valid_q <= 1'b1;
        o_addr_q <= n_addr;
        o_cap_q <= n_cap;
        o_cnt_q <= n_cnt;
        o_st_q <= n_st;
        if (act_q == ACT_CHECKOUT) ckout_q <= ckout_q + 32'd1;
        if (pop) begin
          lh_q[li] <= rd_hdr.next;
          lv_q[li] <= (rd_hdr.next != '0);
          free_tot_q <= free_tot_q - size;
        end
        if (carve) begin
          bump_q <= bump_end[24:0];
          res_tot_q <= res_tot_q + size;
        end
        if (push) begin
          lh_q[hli] <= slot_q;
          lv_q[hli] <= 1'b1;
          free_tot_q <= free_tot_q + hsize;
        end
      end
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.result_address = o_addr_q;
  assign rsp.capacity = o_cap_q;
  assign rsp.ref_count = o_cnt_q;
  assign rsp.status = o_st_q;
  assign rsp.reserved_bytes = res_tot_q;
  assign rsp.free_bytes = free_tot_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !req.ready) else $error("accept while busy");
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC)) else $error("accept lost");
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_q) else $error("result lost");
  a_bump_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q[5:0] == 6'd0) else $error("bump misaligned");
`endif
endmodule
`default_nettype wire

// ----- design/scra_hdr_ram.sv -----
// Header store: single-port-write, one-read synchronous RAM, registered read.
// Depends on scra_pkg.
`default_nettype none
module scra_hdr_ram import scra_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rd_en_i,
  input  wire logic [SlotBits-1:0] rd_addr_i,
  output hdr_t                     rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [SlotBits-1:0] wr_addr_i,
  input  hdr_t                     wr_data_i
);
  hdr_t mem [2**SlotBits];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end
endmodule
`default_nettype wire

// ----- tb/size_class_refcount_allocator_unit_tb.sv -----
// Self-checking testbench for size_class_refcount_allocator_unit.
// Depends on scra_pkg, scra_if and the allocator RTL; predicts every response
// with its own allocator model and checks the responses in order.
`timescale 1ns / 1ps
module size_class_refcount_allocator_unit_tb;
  import scra_pkg::*;

  typedef struct {
    logic [23:0] addr;
    logic [23:0] cap;
    logic [31:0] cnt;
    status_e     st;
    logic [24:0] rsv;
    logic [24:0] fre;
  } alloc_rsp_t;

  // Allocator model plus the queue of responses still owed by the block.
  class alloc_scoreboard;
    longint      bump;
    bit          list_vld[SizeClasses];
    int          list_head[SizeClasses];
    hdr_t        hdrs[int];
    logic [24:0] rsv_total;
    logic [24:0] free_total;
    logic [31:0] checkouts;
    logic [23:0] carved[$];
    alloc_rsp_t  owed[$];
    int          fails;

    function new();
      bump = 64;
      foreach (list_vld[i]) begin
        list_vld[i] = 0;
        list_head[i] = 0;
      end
      rsv_total = '0;
      free_total = '0;
      checkouts = '0;
      fails = 0;
    endfunction

    function bit known(int slot);
      return hdrs.exists(slot);
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note(action_e act, logic [24:0] req, logic [23:0] baddr);
      alloc_rsp_t r;
      int bits, cls, slot, nxt;
      longint size;
      hdr_t h;
      r = '{addr: '0, cap: '0, cnt: '0, st: ST_OK, rsv: '0, fre: '0};
      if (act == ACT_CHECKOUT) begin
        bits = SmallBits;
        while (bits < 40 && (64'd1 << bits) < req) bits++;
        cls = bits - SmallBits;
        checkouts++;
        if (cls >= SizeClasses) begin
          r.st = ST_TOO_LARGE;
        end else begin
          size = 64'd1 << bits;
          if (list_vld[cls]) begin
            // pop the class free list
            slot = list_head[cls];
            nxt = hdrs[slot].next;
            list_head[cls] = nxt;
            list_vld[cls] = (nxt != 0);
            hdrs[slot] = '{next: '0, cls: cls[4:0], count: 32'd1};
            free_total = free_total - size[24:0];
            r.addr = 24'((slot << 6) + 64);
            r.cap = size[23:0];
          end else if (bump + 64 + size > (64'd1 << PoolAddrBits)) begin
            r.st = ST_NO_SPACE;
          end else begin
            // carve header plus block at the bump pointer
            slot = int'(bump >> 6);
            hdrs[slot] = '{next: '0, cls: cls[4:0], count: 32'd1};
            r.addr = 24'(bump + 64);
            r.cap = size[23:0];
            carved.push_back(r.addr);
            bump += 64 + size;
            rsv_total = rsv_total + size[24:0];
          end
        end
      end else if (act == ACT_RESERVE || act == ACT_REMIT) begin
        slot = int'((baddr >> 6) - 1) & ((1 << SlotBits) - 1);
        h = hdrs[slot];
        if (act == ACT_RESERVE) begin
          r.cnt = h.count;
          h.count = h.count + 1;
          hdrs[slot] = h;
        end else if (h.count == 0) begin
          r.st = ST_UNDERFLOW;
        end else begin
          h.count = h.count - 1;
          r.cnt = h.count;
          if (h.count == 0 && h.cls < SizeClasses) begin
            // last reference gone: push onto its class list
            h.next = list_vld[h.cls] ? SlotBits'(list_head[h.cls]) : '0;
            list_head[h.cls] = slot;
            list_vld[h.cls] = 1;
            free_total = free_total + (25'd1 << (SmallBits + h.cls));
          end
          hdrs[slot] = h;
        end
      end
      r.rsv = rsv_total;
      r.fre = free_total;
      owed.push_back(r);
    endfunction

    function void check(alloc_rsp_t got);
      alloc_rsp_t e;
      if (owed.size() == 0) begin
        $display("%0t: response with none expected, addr %h", $time, got.addr);
        fails++;
        return;
      end
      e = owed.pop_front();
      if (got.addr !== e.addr) begin
        $display("%0t: result_address exp %h got %h", $time, e.addr, got.addr);
        fails++;
      end
      if (got.cap !== e.cap) begin
        $display("%0t: capacity exp %h got %h", $time, e.cap, got.cap);
        fails++;
      end
      if (got.cnt !== e.cnt) begin
        $display("%0t: ref_count exp %h got %h", $time, e.cnt, got.cnt);
        fails++;
      end
      if (got.st !== e.st) begin
        $display("%0t: status exp %s got %h", $time, e.st.name(), got.st);
        fails++;
      end
      if (got.rsv !== e.rsv) begin
        $display("%0t: reserved_bytes exp %h got %h", $time, e.rsv, got.rsv);
        fails++;
      end
      if (got.fre !== e.fre) begin
        $display("%0t: free_bytes exp %h got %h", $time, e.fre, got.fre);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  scra_req_if req ();
  scra_rsp_if rsp ();

  size_class_refcount_allocator_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  alloc_scoreboard sb = new();
  bit no_idle;      // phase with back-to-back transfers on both sides
  bit long_hold;    // asks the receiver for one long hold-off

  always #1 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("size_class_refcount_allocator_unit_tb failed");
    $finish;
  end

  // Offer one request and wait for its transfer; model updates at that edge.
  task automatic send(action_e act, logic [24:0] nbytes, logic [23:0] baddr);
    req.valid <= 1'b1;
    req.action <= act;
    req.request_bytes <= nbytes;
    req.block_address <= baddr;
    do @(posedge clk_i); while (!req.ready);
    sb.note(act, nbytes, baddr);
  endtask

  // Mostly short gaps, a few long ones.
  task automatic sender_gap();
    int n;
    if (no_idle) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [24:0] pick_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 75) return 25'($urandom_range(0, 1024));
    if (k < 92) return 25'($urandom_range(0, 65536));
    if (k < 98) return 25'(1 << $urandom_range(6, 23)) - 25'($urandom_range(0, 1));
    return 25'($urandom_range(8388609, 16777216));
  endfunction

  task automatic send_random();
    int k;
    logic [23:0] blk;
    k = $urandom_range(0, 99);
    if (sb.carved.size() == 0 || k < 35) begin
      send(ACT_CHECKOUT, pick_size(), 24'($urandom));
    end else if (k < 97) begin
      blk = sb.carved[$urandom_range(0, sb.carved.size() - 1)];
      // low six bits are don't-care
      blk[5:0] = 6'($urandom);
      if (k == 96 && sb.known((1 << SlotBits) - 1)) blk = 24'($urandom_range(0, 63));
      send(k < 65 ? ACT_RESERVE : ACT_REMIT, 25'($urandom), blk);
    end else begin
      send(ACT_NONE, 25'($urandom), 24'($urandom));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int hold;
    alloc_rsp_t got;
    hold = 0;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        got.addr = rsp.result_address;
        got.cap = rsp.capacity;
        got.cnt = rsp.ref_count;
        got.st = status_e'(rsp.status);
        got.rsv = rsp.reserved_bytes;
        got.fre = rsp.free_bytes;
        sb.check(got);
      end
      if (long_hold) begin
        long_hold = 0;
        hold = 400;
      end else if (hold == 0 && !no_idle && $urandom_range(0, 4) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (hold > 0) hold--;
      rsp.ready <= (hold == 0);
    end
  end

  initial begin
    logic [23:0] a;
    int guard;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.action = ACT_NONE;
    req.request_bytes = '0;
    req.block_address = '0;
    no_idle = 0;
    long_hold = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small requests, largest class, oversize, exhausted pool.
    send(ACT_CHECKOUT, 25'd0, '0);
    send(ACT_CHECKOUT, 25'd64, '0);
    send(ACT_CHECKOUT, 25'd65, '0);
    send(ACT_CHECKOUT, 25'd8388608, '0);
    send(ACT_CHECKOUT, 25'd8388609, '0);
    send(ACT_CHECKOUT, 25'd16777216, '0);
    send(ACT_CHECKOUT, 25'd8388608, '0);
    // Reference counting on the first block: up, down to free, underflow.
    a = sb.carved[0];
    send(ACT_RESERVE, '0, a | 24'h3f);
    send(ACT_REMIT, '1, a);
    send(ACT_REMIT, '0, a);
    send(ACT_REMIT, '0, a);
    send(ACT_CHECKOUT, 25'd1, 24'hffffff);
    send(ACT_NONE, '1, 24'hffffff);
    // Same block freed twice via a fresh reservation in between.
    send(ACT_REMIT, '0, a);
    send(ACT_RESERVE, '0, a);
    send(ACT_REMIT, '0, a);
    send(ACT_CHECKOUT, 25'd64, '0);
    send(ACT_CHECKOUT, 25'd64, '0);

    // Random traffic in phases.
    for (int i = 0; i < 1800; i++) begin
      if (i == 300) no_idle = 1;
      if (i == 500) no_idle = 0;
      if (i == 700) long_hold = 1;   // receiver stalls, block backs up
      if (i == 1000 && sb.owed.size() != 0) begin
        // sender pause until the pipe drains
        req.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk_i);
      end
      send_random();
      sender_gap();
    end
    req.valid <= 1'b0;

    guard = 0;
    while (sb.owed.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("size_class_refcount_allocator_unit_tb passed");
    end else begin
      $display("size_class_refcount_allocator_unit_tb failed");
    end
    $finish;
  end
endmodule
